// File: design/rrsg_pkg.sv
// Shared types, constants and helper functions for the rotated rectangle scan generator.
package rrsg_pkg;

  localparam int MAX_MAP_LOG = 12;

  localparam int CoordW   = 12;
  localparam int ExtW     = 15;
  localparam int LogW     = 4;
  localparam int IdxW     = 24;
  localparam int CurW     = 17;
  localparam int SumW     = CurW + 1;
  localparam int PosW     = SumW + 1;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 15;

  typedef enum logic [CfgAddrW-1:0] {
    REG_BASE_X    = 3'd0,
    REG_BASE_Y    = 3'd1,
    REG_EXTENT_A  = 3'd2,
    REG_EXTENT_B  = 3'd3,
    REG_MAP_LOG_X = 3'd4,
    REG_MAP_LOG_Y = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic clear;
    logic move;
    logic set_finish;
    logic load_out;
    logic out_ok;
  } cmd_t;

  typedef struct packed {
    logic finished;
    logic cell_ok;
    logic b_done;
    logic out_free;
  } status_t;

  function automatic logic [LogW-1:0] eff_log(input logic [LogW-1:0] l);
    return (l > LogW'(MAX_MAP_LOG)) ? LogW'(MAX_MAP_LOG) : l;
  endfunction

  // Halve a signed value with rounding toward zero.
  function automatic logic signed [SumW-1:0] trunc_half(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] adj;
    adj = v + {{(SumW-1){1'b0}}, v[SumW-1]};
    return adj >>> 1;
  endfunction

endpackage

// File: design/rrsg_ctrl.sv
// Controller state machine that sequences restart, advance and result delivery.
module rrsg_ctrl
  import rrsg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    restart,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CELL  = 4'b0010,
    S_NONE  = 4'b0100,
    S_CHECK = 4'b1000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (restart) begin
            cmd.clear  = 1'b1;
            state_next = S_CELL;
          end else if (status.finished) begin
            state_next = S_NONE;
          end else begin
            cmd.move   = 1'b1;
            state_next = S_CHECK;
          end
        end
      end
      S_CELL: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_ok   = status.cell_ok;
          state_next   = S_IDLE;
        end
      end
      S_NONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_CHECK: begin
        if (status.cell_ok || status.b_done) begin
          if (status.out_free) begin
            cmd.load_out   = 1'b1;
            cmd.out_ok     = status.cell_ok && !status.b_done;
            cmd.set_finish = status.b_done;
            state_next     = S_IDLE;
          end
        end else begin
          cmd.move = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/rrsg_datapath.sv
// Datapath holding the registers, the cursors, the cell mapping and the result register.
module rrsg_datapath
  import rrsg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgAddrW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  cmd_t                cmd,
  output status_t             status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CoordW-1:0]   cell_x,
  output logic [CoordW-1:0]   cell_y,
  output logic [IdxW-1:0]     cell_index,
  output logic                valid_res
);

  logic [CoordW-1:0]      base_x, base_y;
  logic signed [ExtW-1:0] extent_a, extent_b;
  logic [LogW-1:0]        map_log_x, map_log_y;

  logic signed [CurW-1:0] cursor_a, cursor_b, cursor_a_next, cursor_b_next;
  logic                   finished;

  logic signed [CurW-1:0] ea, eb;
  logic signed [SumW-1:0] diff, sum, half_x, half_y;
  logic signed [PosW-1:0] pos_x, pos_y, lim_x, lim_y;
  logic [LogW-1:0]        log_x, log_y;
  logic                   on_map;
  logic [IdxW-1:0]        index;

  assign ea = {{(CurW-ExtW){extent_a[ExtW-1]}}, extent_a};
  assign eb = {{(CurW-ExtW){extent_b[ExtW-1]}}, extent_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x    <= '0;
      base_y    <= '0;
      extent_a  <= ExtW'(1);
      extent_b  <= ExtW'(1);
      map_log_x <= LogW'(8);
      map_log_y <= LogW'(8);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE_X:    base_x    <= cfg_data[CoordW-1:0];
        REG_BASE_Y:    base_y    <= cfg_data[CoordW-1:0];
        REG_EXTENT_A:  extent_a  <= cfg_data[ExtW-1:0];
        REG_EXTENT_B:  extent_b  <= cfg_data[ExtW-1:0];
        REG_MAP_LOG_X: map_log_x <= cfg_data[LogW-1:0];
        REG_MAP_LOG_Y: map_log_y <= cfg_data[LogW-1:0];
        default: begin
        end
      endcase
    end
  end

  // One step of the walk: either a saturating b step or an a step with column wrap.
  always_comb begin
    logic signed [CurW-1:0] b_up, b_dn, a_step;
    logic                   wrap;
    b_up          = cursor_b + CurW'(2);
    b_dn          = cursor_b - CurW'(2);
    a_step        = cursor_a;
    wrap          = 1'b0;
    cursor_a_next = cursor_a;
    cursor_b_next = cursor_b;
    if (ea == CurW'(1) || ea == -CurW'(1)) begin
      cursor_a_next = '0;
      if (eb > 0) begin
        cursor_b_next = (b_up < eb) ? b_up : eb;
      end else begin
        cursor_b_next = (b_dn > eb) ? b_dn : eb;
      end
    end else begin
      if (ea > 0) begin
        a_step = cursor_a + CurW'(2);
        wrap   = (a_step >= ea);
      end else begin
        a_step = cursor_a - CurW'(2);
        wrap   = (a_step <= ea);
      end
      if (wrap) begin
        cursor_a_next = a_step[0] ? CurW'(0) : ((ea > 0) ? CurW'(1) : -CurW'(1));
        cursor_b_next = (eb > 0) ? cursor_b + CurW'(1) : cursor_b - CurW'(1);
      end else begin
        cursor_a_next = a_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_a <= '0;
      cursor_b <= '0;
      finished <= 1'b0;
    end else begin
      if (cmd.clear) begin
        cursor_a <= '0;
        cursor_b <= '0;
        finished <= 1'b0;
      end else begin
        if (cmd.move) begin
          cursor_a <= cursor_a_next;
          cursor_b <= cursor_b_next;
        end
        if (cmd.set_finish) begin
          finished <= 1'b1;
        end
      end
    end
  end

  assign diff   = {cursor_a[CurW-1], cursor_a} - {cursor_b[CurW-1], cursor_b};
  assign sum    = {cursor_a[CurW-1], cursor_a} + {cursor_b[CurW-1], cursor_b};
  assign half_x = trunc_half(diff);
  assign half_y = trunc_half(sum);
  assign pos_x  = {{(PosW-CoordW){1'b0}}, base_x} + {half_x[SumW-1], half_x};
  assign pos_y  = {{(PosW-CoordW){1'b0}}, base_y} + {half_y[SumW-1], half_y};
  assign log_x  = eff_log(map_log_x);
  assign log_y  = eff_log(map_log_y);
  assign lim_x  = PosW'(1) << log_x;
  assign lim_y  = PosW'(1) << log_y;
  assign on_map = !pos_x[PosW-1] && !pos_y[PosW-1] && (pos_x < lim_x) && (pos_y < lim_y);
  assign index  = ({{(IdxW-CoordW){1'b0}}, pos_y[CoordW-1:0]} << log_x)
                + {{(IdxW-CoordW){1'b0}}, pos_x[CoordW-1:0]};

  assign status.finished = finished;
  assign status.cell_ok  = on_map;
  assign status.b_done   = (eb > 0) ? (cursor_b >= eb) : (cursor_b <= eb);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cell_x     <= cmd.out_ok ? pos_x[CoordW-1:0] : '0;
      cell_y     <= cmd.out_ok ? pos_y[CoordW-1:0] : '0;
      cell_index <= cmd.out_ok ? index : '0;
      valid_res  <= cmd.out_ok;
    end
  end

endmodule

// File: design/rotated_rect_scan_generator.sv
// Top level of the rotated rectangle scan generator: controller plus datapath.
//
//   channel   direction  handshake               payload
//   in        request    in_valid / in_ready     restart
//   out       result     out_valid / out_ready   cell_x, cell_y, cell_index, valid_res
//   cfg       write      cfg_write               cfg_index, cfg_data
//
// A restart request clears the cursors; an advance after the scan has finished
// leaves them. An advance steps the cursor once when taken and once more per
// skipped off-map position; the cursor step unit moves one position per cycle.
// Reset is synchronous; registers return to their defaults and the cursors clear.
// A new request is taken while a result waits in the output register; the
// result of that request waits until the output register is free.
module rotated_rect_scan_generator
  import rrsg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgAddrW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                restart,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CoordW-1:0]   cell_x,
  output logic [CoordW-1:0]   cell_y,
  output logic [IdxW-1:0]     cell_index,
  output logic                valid_res
);

  cmd_t    cmd;
  status_t status;

  rrsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .restart  (restart),
    .status   (status),
    .cmd      (cmd)
  );

  rrsg_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_index (cell_index),
    .valid_res  (valid_res)
  );

endmodule
